// File: hdl/yolo_row_decode_filter_defines.svh
// assertion macros for the detector row decode filter
// used by yolo_row_decode_filter; expects clk and rst_n in scope
`ifndef YOLO_ROW_DECODE_FILTER_DEFINES_SVH
`define YOLO_ROW_DECODE_FILTER_DEFINES_SVH

// same-cycle implication
`define YRDF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define YRDF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/yrdf_pkg.sv
// shared constants, register indexes and helpers for the row decode filter
// no dependencies
package yrdf_pkg;

    localparam int MAX_CLASSES = 128;
    localparam int FRAC_BITS   = 12;
    localparam int HEAD_LEN    = 5;
    localparam int BOX_LEN     = 4;

    localparam logic [7:0] ROW_MIN = 8'(HEAD_LEN + 1);
    localparam logic [7:0] ROW_MAX = 8'(HEAD_LEN + MAX_CLASSES);

    // 1.0 in the box arithmetic width
    localparam logic signed [19:0] ONE_Q = 20'sd1 <<< FRAC_BITS;

    localparam logic [7:0]  RST_ROW_LENGTH = 8'd85;
    localparam logic [15:0] RST_ROWS       = 16'd25200;
    localparam logic [7:0]  RST_CAP        = 8'd100;
    localparam logic [12:0] RST_THRESHOLD  = 13'd1229;

    typedef enum logic [2:0] {
        REG_ROW_LENGTH  = 3'd0,
        REG_ROWS        = 3'd1,
        REG_CAP         = 3'd2,
        REG_THRESHOLD   = 3'd3,
        REG_SWAP_XY     = 3'd4,
        REG_FLIP_Y      = 3'd5,
        REG_MASK_LOW    = 3'd6,
        REG_MASK_HIGH   = 3'd7
    } cfg_reg_t;

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767)
            r = 16'sh7fff;
        else if (v < -20'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

// File: hdl/yolo_row_decode_filter.sv
// Detector output row decoder: tracks the per-row class maximum, scores and filters each
// row, converts the box centre to a top-left corner and enforces a per-frame detection cap.
// Accepts one tensor element per clock, with no gaps between rows, while in_stall is low. A
// row's result passes from its last element through a row snapshot, a multiply/box stage and a
// filter/cap stage into the output register. The input stalls only when both row stages hold rows and the output
// register holds a result that is itself stalled. Depends on yrdf_pkg and the defines header.
`include "yolo_row_decode_filter_defines.svh"

module yolo_row_decode_filter
    import yrdf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    // element stream
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] element,
    // detections
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] left,
    output logic signed [15:0] top,
    output logic [14:0]        box_width,
    output logic [14:0]        box_height,
    output logic signed [15:0] det_score,
    output logic [6:0]         label,
    output logic [15:0]        row_index
);

    // ---------------- configuration registers ----------------
    logic [7:0]  row_length_reg;
    logic [15:0] rows_reg;
    logic [7:0]  cap_reg;
    logic [12:0] thr_reg;
    logic        swap_reg;
    logic        flip_reg;
    logic [63:0] mask_lo_reg;
    logic [63:0] mask_hi_reg;

    cfg_reg_t    cfg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = cfg_reg_t'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_length_reg <= RST_ROW_LENGTH;
            rows_reg       <= RST_ROWS;
            cap_reg        <= RST_CAP;
            thr_reg        <= RST_THRESHOLD;
            swap_reg       <= 1'b0;
            flip_reg       <= 1'b0;
            mask_lo_reg    <= '0;
            mask_hi_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_ROW_LENGTH: row_length_reg <= pwdata[7:0];
                REG_ROWS:       rows_reg       <= pwdata[15:0];
                REG_CAP:        cap_reg        <= pwdata[7:0];
                REG_THRESHOLD:  thr_reg        <= pwdata[12:0];
                REG_SWAP_XY:    swap_reg       <= pwdata[0];
                REG_FLIP_Y:     flip_reg       <= pwdata[0];
                REG_MASK_LOW:   mask_lo_reg    <= pwdata;
                REG_MASK_HIGH:  mask_hi_reg    <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ROW_LENGTH: prdata = {56'd0, row_length_reg};
            REG_ROWS:       prdata = {48'd0, rows_reg};
            REG_CAP:        prdata = {56'd0, cap_reg};
            REG_THRESHOLD:  prdata = {51'd0, thr_reg};
            REG_SWAP_XY:    prdata = {63'd0, swap_reg};
            REG_FLIP_Y:     prdata = {63'd0, flip_reg};
            REG_MASK_LOW:   prdata = mask_lo_reg;
            REG_MASK_HIGH:  prdata = mask_hi_reg;
            default:        prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic o_ready, emit, pass, s2_take, s1_adv, in_acc;

    // ---------------- row accumulation ----------------
    // data fields are written even in a closed frame: every open row rewrites them all
    logic [7:0]         pos_reg;
    logic [15:0]        row_cnt_reg;
    logic signed [15:0] box_reg [BOX_LEN];
    logic signed [15:0] conf_reg;
    logic signed [15:0] best_reg;
    logic [6:0]         cls_reg;

    logic [7:0]         len_eff;
    logic               row_end;
    logic               take_best;
    logic signed [15:0] best_new;
    logic [6:0]         cls_new;
    logic [15:0]        row_cnt_inc;
    logic               frame_end;

    always_comb
    begin
        if (row_length_reg < ROW_MIN)
            len_eff = ROW_MIN;
        else if (row_length_reg > ROW_MAX)
            len_eff = ROW_MAX;
        else
            len_eff = row_length_reg;
    end

    assign row_end     = ({1'b0, pos_reg} + 9'd1) >= {1'b0, len_eff};
    assign take_best   = (pos_reg == 8'(HEAD_LEN)) || (element > best_reg);
    assign best_new    = take_best ? element : best_reg;
    assign cls_new     = take_best ? 7'(pos_reg - 8'(HEAD_LEN)) : cls_reg;
    assign row_cnt_inc = row_cnt_reg + 16'd1;
    assign frame_end   = row_cnt_inc == rows_reg;
    assign in_acc      = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            row_cnt_reg <= '0;
            best_reg    <= 16'sh8000;
            cls_reg     <= '0;
        end
        else if (in_acc)
        begin
            if (row_end)
            begin
                pos_reg     <= '0;
                best_reg    <= 16'sh8000;
                cls_reg     <= '0;
                row_cnt_reg <= frame_end ? 16'd0 : row_cnt_inc;
            end
            else
            begin
                pos_reg <= pos_reg + 8'd1;
                if (pos_reg >= 8'(HEAD_LEN))
                begin
                    best_reg <= best_new;
                    cls_reg  <= cls_new;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BOX_LEN; i++)
                box_reg[i] <= '0;
            conf_reg <= '0;
        end
        else if (in_acc)
        begin
            if (pos_reg < 8'(BOX_LEN))
                box_reg[pos_reg[1:0]] <= element;
            else if (pos_reg == 8'(BOX_LEN))
                conf_reg <= element;
        end
    end

    // ---------------- stage 1: row snapshot ----------------
    logic signed [15:0] s1_box_reg [BOX_LEN];
    logic signed [15:0] s1_conf_reg;
    logic signed [15:0] s1_best_reg;
    logic [6:0]         s1_cls_reg;
    logic [15:0]        s1_idx_reg;
    logic               s1_last_reg;

    assign s1_adv   = !s2_valid_reg || s2_take;
    assign in_stall = s1_valid_reg && !s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_acc && row_end)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && row_end)
        begin
            for (int i = 0; i < BOX_LEN; i++)
                s1_box_reg[i] <= box_reg[i];
            s1_conf_reg <= conf_reg;
            s1_best_reg <= best_new;
            s1_cls_reg  <= cls_new;
            s1_idx_reg  <= row_cnt_reg;
            s1_last_reg <= frame_end;
        end
    end

    // ---------------- stage 2: score and box ----------------
    logic signed [31:0] prod;
    logic signed [31:0] prod_sh;
    logic signed [15:0] score_c;
    logic signed [15:0] xc, yc, bw, bh;
    logic signed [19:0] xmin, ymin, ymax, top_c;
    logic [127:0]       mask_all;

    assign prod     = s1_best_reg * s1_conf_reg;
    assign prod_sh  = prod >>> FRAC_BITS;
    assign mask_all = {mask_hi_reg, mask_lo_reg};

    always_comb
    begin
        if (prod_sh > 32'sd32767)
            score_c = 16'sh7fff;
        else if (prod_sh < -32'sd32768)
            score_c = 16'sh8000;
        else
            score_c = prod_sh[15:0];

        if (swap_reg)
        begin
            xc = s1_box_reg[0];
            yc = s1_box_reg[1];
            bw = s1_box_reg[2];
            bh = s1_box_reg[3];
        end
        else
        begin
            yc = s1_box_reg[0];
            xc = s1_box_reg[1];
            bh = s1_box_reg[2];
            bw = s1_box_reg[3];
        end

        xmin  = 20'(xc) - 20'(bw >>> 1);
        ymin  = 20'(yc) - 20'(bh >>> 1);
        ymax  = ymin + 20'(bh);
        top_c = flip_reg ? (ONE_Q - ymax) : ymin;
    end

    logic signed [15:0] s2_score_reg;
    logic signed [15:0] s2_left_reg, s2_top_reg;
    logic [14:0]        s2_w_reg, s2_h_reg;
    logic [6:0]         s2_cls_reg;
    logic [15:0]        s2_idx_reg;
    logic               s2_ign_reg, s2_neg_reg, s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            s2_score_reg <= score_c;
            s2_left_reg  <= sat16(xmin);
            s2_top_reg   <= sat16(top_c);
            s2_w_reg     <= bw[14:0];
            s2_h_reg     <= bh[14:0];
            s2_cls_reg   <= s1_cls_reg;
            s2_idx_reg   <= s1_idx_reg;
            s2_ign_reg   <= mask_all[s1_cls_reg];
            s2_neg_reg   <= bw[15] || bh[15];
            s2_last_reg  <= s1_last_reg;
        end
    end

    // ---------------- stage 3: filter, cap, output ----------------
    logic [7:0]         kept_reg;
    logic               closed_reg;
    logic [7:0]         kept_inc;
    logic signed [16:0] score17, thr17;

    assign score17  = {s2_score_reg[15], s2_score_reg};
    assign thr17    = {4'b0000, thr_reg};
    assign pass     = (score17 >= thr17) && !s2_ign_reg;
    assign emit     = s2_valid_reg && !closed_reg && pass && !s2_neg_reg;
    assign o_ready  = !out_valid_reg || !out_stall;
    assign s2_take  = s2_valid_reg && (!emit || o_ready);
    assign kept_inc = kept_reg + 8'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_reg   <= '0;
            closed_reg <= 1'b0;
        end
        else if (s2_take)
        begin
            if (s2_last_reg)
            begin
                kept_reg   <= '0;
                closed_reg <= 1'b0;
            end
            else if (!closed_reg && pass)
            begin
                // negative-size boxes still use a slot
                kept_reg <= kept_inc;
                if (kept_inc >= cap_reg)
                    closed_reg <= 1'b1;
            end
        end
    end

    logic signed [15:0] o_left_reg, o_top_reg, o_score_reg;
    logic [14:0]        o_w_reg, o_h_reg;
    logic [6:0]         o_cls_reg;
    logic [15:0]        o_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (o_ready)
            out_valid_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && emit)
        begin
            o_left_reg  <= s2_left_reg;
            o_top_reg   <= s2_top_reg;
            o_w_reg     <= s2_w_reg;
            o_h_reg     <= s2_h_reg;
            o_score_reg <= s2_score_reg;
            o_cls_reg   <= s2_cls_reg;
            o_idx_reg   <= s2_idx_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign left       = o_left_reg;
    assign top        = o_top_reg;
    assign box_width  = o_w_reg;
    assign box_height = o_h_reg;
    assign det_score  = o_score_reg;
    assign label      = o_cls_reg;
    assign row_index  = o_idx_reg;

    // ---------------- assertions ----------------
    `YRDF_ASSERT_IMP(a_pos_range, 1'b1, pos_reg < ROW_MAX, "element position past longest row")
    `YRDF_ASSERT_NXT(a_row_snap, in_acc && row_end, s1_valid_reg, "row end lost its snapshot")
    `YRDF_ASSERT_NXT(a_frame_reset, s2_take && s2_last_reg, (kept_reg == 8'd0) && !closed_reg,
        "frame end did not reopen the frame")
    `YRDF_ASSERT_IMP(a_out_source, $rose(out_valid_reg), $past(s2_valid_reg) && !$past(closed_reg),
        "detection without a filtered row behind it")

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for yolo_row_decode_filter: streams tensor rows, predicts each
// detection in-line and checks every output transaction field by field
// depends on yrdf_pkg and the row decode filter rtl

module tb_top;
    import yrdf_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int MAX_PHASES     = 40;
    localparam int PRESSURE_PHASE = 0;
    localparam int HOLD_CYCLES    = 400;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [14:0]        box_w;
        logic [14:0]        box_h;
        logic signed [15:0] score;
        logic [6:0]         label;
        logic [15:0]        row;
    } detection_t;

    typedef enum {EXP_MODEL, EXP_GIVEN, EXP_NONE} exp_kind_t;
    typedef enum {STEP_CFG, STEP_ELEM} step_kind_t;

    typedef struct {
        step_kind_t  kind;
        cfg_reg_t    addr;
        logic [63:0] data;
        exp_kind_t   chk;
        detection_t  det;
    } plan_step_t;

    logic               clk;
    logic               rst_n   = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [5:0]         paddr   = '0;
    logic [63:0]        pwdata  = '0;
    logic [63:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] element  = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic [14:0]        box_width;
    logic [14:0]        box_height;
    logic signed [15:0] det_score;
    logic [6:0]         label;
    logic [15:0]        row_index;

    yolo_row_decode_filter u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .element    (element),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .left       (left),
        .top        (top),
        .box_width  (box_width),
        .box_height (box_height),
        .det_score  (det_score),
        .label      (label),
        .row_index  (row_index)
    );

    // register copy
    logic [7:0]  cfg_row_len = RST_ROW_LENGTH;
    logic [15:0] cfg_rows    = RST_ROWS;
    logic [7:0]  cfg_cap     = RST_CAP;
    logic [12:0] cfg_thr     = RST_THRESHOLD;
    logic        cfg_swap    = 1'b0;
    logic        cfg_flip    = 1'b0;
    logic [63:0] mask_lo     = '0;
    logic [63:0] mask_hi     = '0;

    // row and frame state
    logic signed [15:0] box_val [4] = '{default: '0};
    logic signed [15:0] row_conf     = '0;
    logic signed [15:0] best_val     = 16'sh8000;
    logic [6:0]         best_cls     = '0;
    logic [7:0]         elem_pos     = '0;
    logic [15:0]        row_cnt      = '0;
    logic [7:0]         kept_cnt     = '0;
    logic               frame_closed = 1'b0;

    detection_t         pending_dets [$];
    logic signed [15:0] last_score_val = '0;
    int                 mismatches = 0;
    int                 items_sent = 0;
    int                 cycle_count = 0;
    int                 send_pct = 0;
    int                 recv_pct = 0;
    int                 phase_id = -1;

    // short rows of the directed part: length 3 reads as 6, frame of 3 rows, cap of 2
    plan_step_t plan [28] = '{
        '{STEP_CFG,  REG_ROW_LENGTH, 64'd3,     EXP_NONE,  '0},
        '{STEP_CFG,  REG_ROWS,       64'd3,     EXP_NONE,  '0},
        '{STEP_CFG,  REG_CAP,        64'd2,     EXP_NONE,  '0},
        '{STEP_CFG,  REG_THRESHOLD,  64'd0,     EXP_NONE,  '0},
        // plain box, emitted as row 0
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd4096,  EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd2048,  EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd1024,  EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd512,   EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd4096,  EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd2048,  EXP_GIVEN,
            '{16'sd1792, 16'sd3584, 15'd512, 15'd1024, 16'sd2048, 7'd0, 16'd0}},
        // negative height takes the last slot, nothing emitted
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd0,     EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd0,     EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'h8000,  EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd100,   EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd4096,  EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd4096,  EXP_NONE,  '0},
        // frame closed, row skipped, frame ends here
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd0,     EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd0,     EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd100,   EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd100,   EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd4096,  EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd4096,  EXP_NONE,  '0},
        // extremes in a fresh frame: saturated left and score
        '{STEP_ELEM, REG_ROW_LENGTH, 64'h7fff,  EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'h8000,  EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'h7fff,  EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'd2,     EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'h7fff,  EXP_MODEL, '0},
        '{STEP_ELEM, REG_ROW_LENGTH, 64'h7fff,  EXP_GIVEN,
            '{16'sh8000, 16'sd16384, 15'd2, 15'd32767, 16'sh7fff, 7'd0, 16'd0}}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic signed [15:0] clamp16(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic void apply_reg(input cfg_reg_t r, input logic [63:0] d);
        case (r)
            REG_ROW_LENGTH: cfg_row_len = d[7:0];
            REG_ROWS:       cfg_rows    = d[15:0];
            REG_CAP:        cfg_cap     = d[7:0];
            REG_THRESHOLD:  cfg_thr     = d[12:0];
            REG_SWAP_XY:    cfg_swap    = d[0];
            REG_FLIP_Y:     cfg_flip    = d[0];
            REG_MASK_LOW:   mask_lo     = d;
            REG_MASK_HIGH:  mask_hi     = d;
            default: ;
        endcase
    endfunction

    // consumes one element; returns 1 with the detection when a row is emitted
    function automatic bit decode_element(input logic signed [15:0] v, output detection_t det);
        int len, pos, score, xc, yc, w, h, xmin, ymin, ymax;
        bit hit, masked;
        hit = 1'b0;
        det = '0;
        len = int'(cfg_row_len);
        if (len < HEAD_LEN + 1)
            len = HEAD_LEN + 1;
        if (len > HEAD_LEN + MAX_CLASSES)
            len = HEAD_LEN + MAX_CLASSES;
        pos = int'(elem_pos);
        if (!frame_closed)
        begin
            if (pos < BOX_LEN)
                box_val[pos] = v;
            else if (pos == BOX_LEN)
                row_conf = v;
            else if (pos == HEAD_LEN || v > best_val)
            begin
                best_val = v;
                best_cls = 7'(pos - HEAD_LEN);
            end
        end
        if (pos + 1 < len)
        begin
            elem_pos = 8'(pos + 1);
            return 1'b0;
        end
        if (!frame_closed)
        begin
            score = int'(clamp16((int'(best_val) * int'(row_conf)) >>> FRAC_BITS));
            masked = best_cls[6] ? mask_hi[best_cls[5:0]] : mask_lo[best_cls[5:0]];
            if (score >= int'(cfg_thr) && !masked)
            begin
                kept_cnt = kept_cnt + 8'd1;
                if (kept_cnt >= cfg_cap)
                    frame_closed = 1'b1;
                if (cfg_swap)
                begin
                    xc = box_val[0]; yc = box_val[1]; w = box_val[2]; h = box_val[3];
                end
                else
                begin
                    yc = box_val[0]; xc = box_val[1]; h = box_val[2]; w = box_val[3];
                end
                // negative size still used up its slot above
                if (w >= 0 && h >= 0)
                begin
                    xmin = xc - (w >>> 1);
                    ymin = yc - (h >>> 1);
                    ymax = ymin + h;
                    det.left  = clamp16(xmin);
                    det.top   = clamp16(cfg_flip ? (1 << FRAC_BITS) - ymax : ymin);
                    det.box_w = 15'(w);
                    det.box_h = 15'(h);
                    det.score = 16'(score);
                    det.label = best_cls;
                    det.row   = row_cnt;
                    hit = 1'b1;
                end
            end
        end
        elem_pos = '0;
        best_val = 16'sh8000;
        best_cls = '0;
        row_cnt  = row_cnt + 16'd1;
        if (row_cnt == cfg_rows)
        begin
            row_cnt      = '0;
            kept_cnt     = '0;
            frame_closed = 1'b0;
        end
        return hit;
    endfunction

    // mostly well-formed rows, a little noise; clean rows always pass a zero threshold
    function automatic logic signed [15:0] gen_element(input bit clean);
        int r;
        logic signed [15:0] v;
        r = $urandom_range(99);
        if (!clean && r < 8)
            return 16'($urandom);
        r = $urandom_range(99);
        if (elem_pos < BOX_LEN)
        begin
            if (clean || r < 75)
                v = 16'($urandom_range(8192));
            else if (r < 87)
                v = 16'(-int'($urandom_range(4096, 1)));
            else if (r < 94)
                v = r[0] ? 16'sh7fff : 16'sh8000;
            else
                v = 16'($urandom);
        end
        else if (elem_pos == BOX_LEN)
        begin
            if (clean || r < 80)
                v = 16'($urandom_range(8192, 1024));
            else if (r < 90)
                v = 16'(-int'($urandom_range(4096)));
            else
                v = 16'($urandom);
        end
        else
        begin
            if (clean)
                v = 16'($urandom_range(8192));
            else if (r < 20 && elem_pos > HEAD_LEN)
                v = last_score_val;  // tie with the previous class
            else if (r < 85)
                v = 16'(int'($urandom_range(8192)) - 2048);
            else
                v = 16'($urandom);
            last_score_val = v;
        end
        return v;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [63:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        apply_reg(r, d);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // bus returns to idle between transfers
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_dets.size() != 0)
            @(posedge clk);
        // rows that end without a detection may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic push_element(input logic signed [15:0] v, input exp_kind_t chk,
                                input detection_t given);
        detection_t det;
        bit hit;
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        element  <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        hit = decode_element(v, det);
        if (chk == EXP_GIVEN)
            pending_dets.push_back(given);
        else if (chk == EXP_MODEL && hit)
            pending_dets.push_back(det);
        items_sent++;
    endtask

    // receiver: random stall, plus one long hold-off in the pressure phase
    initial
    begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase_id == PRESSURE_PHASE && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    always @(posedge clk)
    begin : check_dets
        detection_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_dets.size() == 0)
                flag_mismatch("detection with none pending, row_index", int'(row_index), -1);
            else
            begin
                want = pending_dets.pop_front();
                if (left !== want.left)
                    flag_mismatch("left", int'(left), int'(want.left));
                if (top !== want.top)
                    flag_mismatch("top", int'(top), int'(want.top));
                if (box_width !== want.box_w)
                    flag_mismatch("box_width", int'(box_width), int'(want.box_w));
                if (box_height !== want.box_h)
                    flag_mismatch("box_height", int'(box_height), int'(want.box_h));
                if (det_score !== want.score)
                    flag_mismatch("det_score", int'(det_score), int'(want.score));
                if (label !== want.label)
                    flag_mismatch("label", int'(label), int'(want.label));
                if (row_index !== want.row)
                    flag_mismatch("row_index", int'(row_index), int'(want.row));
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        int phase, r, n;
        logic [7:0]  rl, cap;
        logic [15:0] rows;
        logic [12:0] thr;
        logic        swp, flp, clean;
        logic [63:0] mlo, mhi;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_CFG)
            begin
                wait_idle();
                write_reg(plan[i].addr, plan[i].data);
            end
            else
                push_element(16'(plan[i].data), plan[i].chk, plan[i].det);
        end

        phase = 0;
        while (items_sent < RANDOM_ITEMS && phase < MAX_PHASES)
        begin
            wait_idle();
            if (phase == PRESSURE_PHASE)
            begin
                // short clean rows that all pass, in a frame that never wraps here
                rl = 8'd6; rows = 16'd0; cap = 8'd255; thr = '0;
                mlo = '0; mhi = '0;
            end
            else
            begin
                r = $urandom_range(19);
                rl = (r == 0) ? 8'd255 : (r == 1) ? 8'd133 :
                     (r == 2) ? 8'($urandom_range(5)) : 8'($urandom_range(14, 6));
                r = $urandom_range(19);
                rows = (r == 0) ? 16'd0 : (r == 1) ? 16'd65535 : (r == 2) ? 16'd1 :
                       16'(row_cnt + $urandom_range(12, 1));
                r = $urandom_range(19);
                cap = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(8, 1));
                r = $urandom_range(9);
                thr = (r == 0) ? 13'd0 : (r == 1) ? 13'd4096 : 13'($urandom_range(2048));
                r = $urandom_range(19);
                mlo = (r < 10) ? 64'd0 : (r == 10) ? '1 :
                      {$urandom, $urandom} & {$urandom, $urandom};
                r = $urandom_range(19);
                mhi = (r < 10) ? 64'd0 : (r == 10) ? '1 :
                      {$urandom, $urandom} & {$urandom, $urandom};
            end
            swp = 1'($urandom_range(1));
            flp = 1'($urandom_range(1));
            write_reg(REG_ROW_LENGTH, 64'(rl));
            write_reg(REG_ROWS, 64'(rows));
            write_reg(REG_CAP, 64'(cap));
            write_reg(REG_THRESHOLD, 64'(thr));
            write_reg(REG_SWAP_XY, 64'(swp));
            write_reg(REG_FLIP_Y, 64'(flp));
            write_reg(REG_MASK_LOW, mlo);
            write_reg(REG_MASK_HIGH, mhi);

            case (phase % 4)
                0: begin send_pct = 0;  recv_pct <= 0;  end
                1: begin send_pct = 88; recv_pct <= 0;  end
                2: begin send_pct = 0;  recv_pct <= 88; end
                default: begin send_pct = 37; recv_pct <= 37; end
            endcase
            phase_id <= phase;
            clean = (phase == PRESSURE_PHASE);
            n = (phase == PRESSURE_PHASE) ? 150 : (rl >= 8'd100) ? 300 : $urandom_range(130, 60);
            // phases end at any element, so the next length change can land mid-row
            repeat (n) push_element(gen_element(clean), EXP_MODEL, '0);
            phase++;
        end

        wait_idle();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
